// File: design/u2l_pkg.sv
`default_nettype none

package u2l_pkg;

    // Byte values that classify a lead byte.
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;

    // Masks applied to lead bytes.
    localparam logic [7:0] LEAD2_MASK = 8'd63;
    localparam logic [7:0] LEAD3_MASK = 8'd15;
    localparam logic [7:0] LEAD4_MASK = 8'd7;

    // Replacement character for unrepresentable or truncated sequences.
    localparam logic [7:0] QMARK = 8'h3F;

    // Continuation counts loaded by each kind of lead byte.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_TWO  = 2'd1;
    localparam logic [1:0] PEND_THREE = 2'd2;
    localparam logic [1:0] PEND_FOUR = 2'd3;

    // One result handed from the decoder to the output stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } result_t;

endpackage

`default_nettype wire

// File: design/u2l_core.sv
`default_nettype none

module u2l_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [7:0]      in_byte,
    input  wire logic            is_last,
    output u2l_pkg::result_t     result
);

    // Decoder state. The accumulator keeps only the low 8 bits of the code
    // point; the big flag records that a higher bit has ever been set, which
    // is all that is needed to choose between the value and the replacement.
    logic [1:0] pending_reg, pending_next;
    logic [7:0] acc_reg, acc_next;
    logic       big_reg, big_next;

    logic [7:0] acc_shift;
    logic       big_shift;
    logic [1:0] pending_dec;

    // Continuation byte contribution.
    always_comb
    begin
        acc_shift   = {acc_reg[1:0], in_byte[5:0]};
        big_shift   = big_reg | (acc_reg[7:2] != 6'd0);
        pending_dec = pending_reg - 2'd1;
    end

    // Next-state and result logic for one transfer.
    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        big_next     = big_reg;
        result.valid = 1'b0;
        result.data  = in_byte;
        if (fire)
        begin
            if (pending_reg != u2l_pkg::PEND_NONE)
            begin
                if (pending_dec == u2l_pkg::PEND_NONE)
                begin
                    result.valid = 1'b1;
                    result.data  = big_shift ? u2l_pkg::QMARK : acc_shift;
                    pending_next = u2l_pkg::PEND_NONE;
                    acc_next     = 8'd0;
                    big_next     = 1'b0;
                end
                else if (is_last)
                begin
                    result.valid = 1'b1;
                    result.data  = u2l_pkg::QMARK;
                    pending_next = u2l_pkg::PEND_NONE;
                    acc_next     = 8'd0;
                    big_next     = 1'b0;
                end
                else
                begin
                    pending_next = pending_dec;
                    acc_next     = acc_shift;
                    big_next     = big_shift;
                end
            end
            else if (in_byte < u2l_pkg::LEAD2_MIN)
            begin
                // Plain byte, including a stray continuation byte.
                result.valid = 1'b1;
                result.data  = in_byte;
            end
            else if (is_last)
            begin
                // Lead byte at the end of the stream.
                result.valid = 1'b1;
                result.data  = u2l_pkg::QMARK;
                pending_next = u2l_pkg::PEND_NONE;
                acc_next     = 8'd0;
                big_next     = 1'b0;
            end
            else
            begin
                big_next = 1'b0;
                if (in_byte >= u2l_pkg::LEAD4_MIN)
                begin
                    acc_next     = in_byte & u2l_pkg::LEAD4_MASK;
                    pending_next = u2l_pkg::PEND_FOUR;
                end
                else if (in_byte >= u2l_pkg::LEAD3_MIN)
                begin
                    acc_next     = in_byte & u2l_pkg::LEAD3_MASK;
                    pending_next = u2l_pkg::PEND_THREE;
                end
                else
                begin
                    acc_next     = in_byte & u2l_pkg::LEAD2_MASK;
                    pending_next = u2l_pkg::PEND_TWO;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= u2l_pkg::PEND_NONE;
            acc_reg     <= 8'd0;
            big_reg     <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            big_reg     <= big_next;
        end
    end

endmodule

`default_nettype wire

// File: design/u2l_out_buf.sv
`default_nettype none

module u2l_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire u2l_pkg::result_t result,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            out_byte
);

    // Output register plus one skid entry.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] skid_data_reg, skid_data_next;

    // Move results between the incoming side, skid entry and output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result.data;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = result.data;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_data_reg;

endmodule

`default_nettype wire

// File: design/utf8_to_latin1_decoder_unit.sv
`default_nettype none

// UTF-8 to Latin-1 decoder.
// Input channel: in_valid, in_stall, in_byte, is_last. A byte transfers at a
// rising edge with in_valid high and in_stall low. is_last marks the final
// byte of a stream; the decoder returns to its reset state after it.
// Output channel: out_valid, out_stall, out_byte. A character transfers at a
// rising edge with out_valid high and out_stall low.
// Each input byte gives zero or one character: plain bytes and completed
// sequences give one, bytes inside a sequence give none, and a sequence cut
// short by is_last gives one '?'.
// The output register takes a character from the byte that completes it, or
// the skid entry does while a held output is stalled. Throughput is one byte
// per cycle while in_stall is low, set by the single decode step between the
// state registers and the output register.
// While the receiver stalls, one further result is held in a skid entry;
// in_stall rises only when that entry is occupied and drops as soon as the
// output register drains.
// Reset clears the sequence state and empties the output and skid entries.
module utf8_to_latin1_decoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte
);

    u2l_pkg::result_t result;
    logic             fire;
    logic             full;

    assign in_stall = full;
    assign fire     = in_valid && !full;

    // Sequence decoder.
    u2l_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte),
        .is_last (is_last),
        .result  (result)
    );

    // Output register with skid entry.
    u2l_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

    // The skid entry is occupied only behind a held output.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid entry occupied without a held output");

    // The last byte of a stream always yields a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && is_last) |=> out_valid)
        else $error("no character after the last byte of a stream");

    // A result taken while the output register is empty is passed through next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.valid && !out_valid) |=> (out_valid && out_byte == $past(result.data)))
        else $error("result lost on the way to an empty output register");

endmodule

`default_nettype wire

// File: test/latin1_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the decoder, predicts each decoded character from
// the accepted input bytes, and compares the characters that come out.
module latin1_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_last,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    output int              fail_count,
    output int              pending
);

    // Predicted sequence state.
    logic [1:0]  seq_left;
    logic [20:0] code_acc;

    // Characters predicted but not yet seen on the output channel.
    logic [7:0]  expected_chars[$];
    logic [7:0]  want;

    // Advance the predicted state by one byte and queue any character it yields.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [20:0] acc_next;
        if (seq_left != u2l_pkg::PEND_NONE)
        begin
            // Any byte inside a sequence counts as a continuation: low 6 bits.
            acc_next = {code_acc[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == u2l_pkg::PEND_NONE)
            begin
                expected_chars.push_back((acc_next > 21'h0000FF) ? u2l_pkg::QMARK
                                                                 : acc_next[7:0]);
                code_acc = '0;
            end
            else if (last)
            begin
                seq_left = u2l_pkg::PEND_NONE;
                code_acc = '0;
                expected_chars.push_back(u2l_pkg::QMARK);
            end
            else
            begin
                code_acc = acc_next;
            end
        end
        else if (b < u2l_pkg::LEAD2_MIN)
        begin
            // Plain bytes and stray continuation bytes pass through.
            expected_chars.push_back(b);
        end
        else
        begin
            if (b >= u2l_pkg::LEAD4_MIN)
            begin
                code_acc = 21'(b & u2l_pkg::LEAD4_MASK);
                seq_left = u2l_pkg::PEND_FOUR;
            end
            else if (b >= u2l_pkg::LEAD3_MIN)
            begin
                code_acc = 21'(b & u2l_pkg::LEAD3_MASK);
                seq_left = u2l_pkg::PEND_THREE;
            end
            else
            begin
                code_acc = 21'(b & u2l_pkg::LEAD2_MASK);
                seq_left = u2l_pkg::PEND_TWO;
            end
            // A lead byte that ends the stream is a truncated sequence.
            if (last)
            begin
                seq_left = u2l_pkg::PEND_NONE;
                code_acc = '0;
                expected_chars.push_back(u2l_pkg::QMARK);
            end
        end
    endtask

    // Compare output transfers first, then predict from the input transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_left = u2l_pkg::PEND_NONE;
            code_acc = '0;
            expected_chars.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("out_byte: expected no transfer, actual %h", out_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_byte !== want)
                    begin
                        $error("out_byte: expected %h, actual %h", want, out_byte);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, is_last);
            end
        end
        pending = expected_chars.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TOTAL_ITEMS = 1975;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN       = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       is_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;

    int fail_count;
    int pending;
    int sent_cnt = 0;
    bit calm     = 1'b0;

    // Directed bytes: bit 8 is the end-of-stream mark, bits 7:0 the byte.
    logic [8:0] directed_seq[$] = '{
        9'h000, 9'h07F, 9'h080, 9'h1BF,      // plain, stray continuation, stray at end
        9'h0C0, 9'h080,                      // two-byte, value zero
        9'h0C3, 9'h0BF,                      // two-byte, value 0xFF
        9'h0DF, 9'h0BF,                      // two-byte, too large
        9'h0E0, 9'h083, 9'h0BF,              // overlong three-byte, value 0xFF
        9'h0EF, 9'h0BF, 9'h0BF,              // three-byte, too large
        9'h0F8, 9'h080, 9'h081, 9'h0BF,      // lead above 0xF7 as a four-byte lead
        9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,      // largest lead, too large
        9'h0C2, 9'h0E0,                      // lead byte taken as a continuation
        9'h1C5,                              // lead byte at end of stream
        9'h0F0, 9'h190                       // four-byte cut short
    };

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    utf8_to_latin1_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

    latin1_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one byte, after an occasional idle burst, and wait for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= last;
        do @(posedge clk); while (in_stall);
        sent_cnt++;
    endtask

    // Receiver: one long hold-off to fill the block, otherwise short random stalls.
    initial
    begin
        bit squeezed;
        squeezed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!squeezed && sent_cnt >= HOLD_AT)
            begin
                squeezed = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Cycle counter that ends a hung run.
    initial
    begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Stimulus: directed bytes, then random characters, mostly well-formed.
    initial
    begin
        int         kind;
        int         nbytes;
        int         cut;
        logic [7:0] lead;
        logic [7:0] cont;
        logic       end_mark;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_seq[i])
        begin
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        end

        while (sent_cnt < TOTAL_ITEMS)
        begin
            if (sent_cnt >= TOTAL_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            kind     = $urandom_range(0, 99);
            end_mark = ($urandom_range(0, 15) == 0);
            if (kind < 35)
            begin
                send_byte(8'($urandom_range(0, 127)), end_mark);
            end
            else if (kind < 45)
            begin
                // Stray continuation byte outside any sequence.
                send_byte(8'($urandom_range(128, 191)), end_mark);
            end
            else
            begin
                if (kind < 70)
                begin
                    nbytes = 2;
                    // Favor leads whose sequences fit in one byte.
                    lead = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(192, 195))
                                                       : 8'($urandom_range(192, 223));
                end
                else if (kind < 85)
                begin
                    nbytes = 3;
                    lead   = 8'($urandom_range(224, 239));
                end
                else
                begin
                    nbytes = 4;
                    lead   = 8'($urandom_range(240, 255));
                end
                // Now and then the stream ends before the sequence is complete.
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nbytes - 1) : nbytes;
                send_byte(lead, (cut == 1) ? 1'b1 : 1'b0);
                for (int i = 2; i <= cut; i++)
                begin
                    cont = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : {2'b10, 6'($urandom)};
                    send_byte(cont, (i == cut) ? ((cut < nbytes) || end_mark) : 1'b0);
                end
            end
        end
        in_valid <= 1'b0;

        // Drain the outstanding characters, then keep watching the output.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
